// File: hw/rtl/idea_block_cipher_unit_macros.svh
// Assertion helpers used by the checker file ideau_checker.sv.
`ifndef IDEA_BLOCK_CIPHER_UNIT_MACROS_SVH
`define IDEA_BLOCK_CIPHER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define IDEAU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define IDEAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ideau_pkg.sv
package ideau_pkg;

    localparam int ROUND_COUNT = 8;
    localparam int KEY_COUNT   = 6 * ROUND_COUNT + 4;
    localparam int KEY_IDX_W   = $clog2(KEY_COUNT);
    localparam int RND_W       = $clog2(ROUND_COUNT + 1);
    localparam int LAST_SRC    = 6 * ROUND_COUNT;

    localparam logic [1:0] CFG_KEY_FIRST  = 2'd0;
    localparam logic [1:0] CFG_KEY_SECOND = 2'd1;
    localparam logic [1:0] CFG_MODE       = 2'd2;

    typedef logic [15:0] word_t;

    typedef struct packed {
        word_t w0;
        word_t w1;
        word_t w2;
        word_t w3;
    } blk_t;

    typedef enum logic [1:0] {
        KS_IDLE,
        KS_FETCH,
        KS_INV
    } ks_state_t;

    typedef enum logic [1:0] {
        KOP_PLAIN,
        KOP_NEG,
        KOP_INV
    } key_op_t;

    // Multiplication modulo 65537 with the word 0 standing for 65536.
    // Since 65536 is -1 modulo 65537, the product reduces as low half minus high half.
    function automatic word_t mulmod(word_t x, word_t y);
        logic [16:0] a;
        logic [16:0] b;
        logic [33:0] p;
        logic [17:0] d;
        a = (x == 16'h0000) ? 17'h10000 : {1'b0, x};
        b = (y == 16'h0000) ? 17'h10000 : {1'b0, y};
        p = a * b;
        d = {2'b00, p[15:0]} - {1'b0, p[32:16]};
        if ({1'b0, p[15:0]} < p[32:16])
        begin
            d = d + 18'h10001;
        end
        return d[15:0];
    endfunction

endpackage

// File: hw/rtl/ideau_key_sched.sv
module ideau_key_sched (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [63:0]                          cfg_data,
    output logic                                 busy,
    output logic [ideau_pkg::KEY_COUNT*16-1:0]   keys
);

    localparam int KC = ideau_pkg::KEY_COUNT;
    localparam int IW = ideau_pkg::KEY_IDX_W;
    localparam int RW = ideau_pkg::RND_W;

    ideau_pkg::ks_state_t state_reg, state_next;

    logic [63:0]          key_hi_reg;
    logic [63:0]          key_lo_reg;
    logic                 mode_reg;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [RW-1:0]        rnd_reg, rnd_next;
    logic [2:0]           pos_reg, pos_next;
    logic [3:0]           cnt_reg, cnt_next;
    ideau_pkg::word_t     acc_reg, acc_next;
    ideau_pkg::word_t     sq_reg, sq_next;
    ideau_pkg::word_t     tab_reg [KC];

    logic                 cfg_hit;
    logic                 last_key;
    logic                 tab_we;
    logic                 step;
    ideau_pkg::word_t     tab_wdata;
    logic [IW-1:0]        src;
    ideau_pkg::key_op_t   op;
    logic [IW-1:0]        six_r;
    logic [IW-1:0]        s_base;
    logic [IW-1:0]        t_base;
    logic                 edge_rnd;
    logic [255:0]         key_dbl;
    logic [7:0]           rot;
    logic [6:0]           off;
    logic [7:0]           sel;
    ideau_pkg::word_t     enc_word;

    assign cfg_hit  = cfg_we && (cfg_index == ideau_pkg::CFG_KEY_FIRST
                      || cfg_index == ideau_pkg::CFG_KEY_SECOND
                      || cfg_index == ideau_pkg::CFG_MODE);
    assign last_key = (idx_reg == IW'(KC - 1));
    assign busy     = (state_reg != ideau_pkg::KS_IDLE);

    // Source word and operation for the table entry in progress.
    always_comb
    begin
        six_r    = IW'({rnd_reg, 2'b00}) + IW'({rnd_reg, 1'b0});
        s_base   = IW'(ideau_pkg::LAST_SRC) - six_r;
        t_base   = IW'(ideau_pkg::LAST_SRC - 6) - six_r;
        edge_rnd = (rnd_reg == '0) || (rnd_reg == RW'(ideau_pkg::ROUND_COUNT));
        src      = idx_reg;
        op       = ideau_pkg::KOP_PLAIN;
        if (mode_reg)
        begin
            case (pos_reg)
                3'd0:
                begin
                    src = s_base;
                    op  = ideau_pkg::KOP_INV;
                end
                3'd1:
                begin
                    src = s_base + (edge_rnd ? IW'(1) : IW'(2));
                    op  = ideau_pkg::KOP_NEG;
                end
                3'd2:
                begin
                    src = s_base + (edge_rnd ? IW'(2) : IW'(1));
                    op  = ideau_pkg::KOP_NEG;
                end
                3'd3:
                begin
                    src = s_base + IW'(3);
                    op  = ideau_pkg::KOP_INV;
                end
                3'd4:
                begin
                    src = t_base + IW'(4);
                end
                3'd5:
                begin
                    src = t_base + IW'(5);
                end
                default:
                begin
                    src = idx_reg;
                end
            endcase
        end
    end

    // Word src of the expanded key: the key rotated left 25 bits per group of eight.
    always_comb
    begin
        key_dbl  = {key_hi_reg, key_lo_reg, key_hi_reg, key_lo_reg};
        rot      = {2'b00, src[5:3], 3'b000} + {1'b0, src[5:3], 4'b0000}
                   + {5'b00000, src[5:3]};
        off      = rot[6:0] + {src[2:0], 4'b0000};
        sel      = 8'd240 - {1'b0, off};
        enc_word = key_dbl[sel +: 16];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ideau_pkg::KS_IDLE:
            begin
                if (cfg_hit)
                begin
                    state_next = ideau_pkg::KS_FETCH;
                end
            end
            ideau_pkg::KS_FETCH:
            begin
                if (cfg_hit)
                begin
                    state_next = ideau_pkg::KS_FETCH;
                end
                else if (op == ideau_pkg::KOP_INV)
                begin
                    state_next = ideau_pkg::KS_INV;
                end
                else if (last_key)
                begin
                    state_next = ideau_pkg::KS_IDLE;
                end
            end
            ideau_pkg::KS_INV:
            begin
                if (cfg_hit)
                begin
                    state_next = ideau_pkg::KS_FETCH;
                end
                else if (cnt_reg == 4'hF)
                begin
                    state_next = last_key ? ideau_pkg::KS_IDLE : ideau_pkg::KS_FETCH;
                end
            end
            default:
            begin
                state_next = ideau_pkg::KS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        tab_we    = 1'b0;
        step      = 1'b0;
        tab_wdata = enc_word;
        acc_next  = ideau_pkg::mulmod(acc_reg, sq_reg);
        sq_next   = ideau_pkg::mulmod(sq_reg, sq_reg);
        cnt_next  = cnt_reg + 4'd1;
        case (state_reg)
            ideau_pkg::KS_FETCH:
            begin
                acc_next = 16'h0001;
                sq_next  = enc_word;
                cnt_next = 4'd0;
                if (op != ideau_pkg::KOP_INV)
                begin
                    tab_we    = 1'b1;
                    step      = 1'b1;
                    tab_wdata = (op == ideau_pkg::KOP_NEG) ? (16'h0000 - enc_word) : enc_word;
                end
            end
            ideau_pkg::KS_INV:
            begin
                if (cnt_reg == 4'hF)
                begin
                    tab_we    = 1'b1;
                    step      = 1'b1;
                    tab_wdata = acc_next;
                end
            end
            default:
            begin
                cnt_next = 4'd0;
            end
        endcase
        if (cfg_hit)
        begin
            tab_we = 1'b0;
            step   = 1'b0;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        rnd_next = rnd_reg;
        pos_next = pos_reg;
        if (cfg_hit)
        begin
            idx_next = '0;
            rnd_next = '0;
            pos_next = 3'd0;
        end
        else if (step)
        begin
            idx_next = idx_reg + IW'(1);
            if (pos_reg == 3'd5)
            begin
                pos_next = 3'd0;
                rnd_next = rnd_reg + RW'(1);
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ideau_pkg::KS_IDLE;
            key_hi_reg <= '0;
            key_lo_reg <= '0;
            mode_reg   <= 1'b0;
            idx_reg    <= '0;
            rnd_reg    <= '0;
            pos_reg    <= 3'd0;
            cnt_reg    <= 4'd0;
            for (int i = 0; i < KC; i++)
            begin
                tab_reg[i] <= 16'h0000;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rnd_reg   <= rnd_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            if (cfg_we && cfg_index == ideau_pkg::CFG_KEY_FIRST)
            begin
                key_hi_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == ideau_pkg::CFG_KEY_SECOND)
            begin
                key_lo_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == ideau_pkg::CFG_MODE)
            begin
                mode_reg <= cfg_data[0];
            end
            if (tab_we)
            begin
                tab_reg[idx_reg] <= tab_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
    end

    always_comb
    begin
        for (int i = 0; i < KC; i++)
        begin
            keys[16*i +: 16] = tab_reg[i];
        end
    end

endmodule

// File: hw/rtl/ideau_round_cell.sv
module ideau_round_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [95:0]       keys,
    input  logic              up_valid,
    output logic              up_ready,
    input  ideau_pkg::blk_t   up_blk,
    output logic              dn_valid,
    input  logic              dn_ready,
    output ideau_pkg::blk_t   dn_blk
);

    ideau_pkg::word_t z0, z1, z2, z3, z4, z5;

    logic             a_v_reg, b_v_reg, c_v_reg;
    logic             a_en, b_en, c_en;
    ideau_pkg::blk_t  a_reg, b_reg, c_reg;
    ideau_pkg::blk_t  a_next, b_next, c_next;
    ideau_pkg::word_t m_reg, m_next;
    ideau_pkg::word_t n;
    ideau_pkg::word_t s;

    assign z0 = keys[15:0];
    assign z1 = keys[31:16];
    assign z2 = keys[47:32];
    assign z3 = keys[63:48];
    assign z4 = keys[79:64];
    assign z5 = keys[95:80];

    // Each stage moves when it is empty or the stage after it moves.
    assign c_en     = !c_v_reg || dn_ready;
    assign b_en     = !b_v_reg || c_en;
    assign a_en     = !a_v_reg || b_en;
    assign up_ready = a_en;

    always_comb
    begin
        a_next.w0 = ideau_pkg::mulmod(up_blk.w0, z0);
        a_next.w1 = up_blk.w1 + z1;
        a_next.w2 = up_blk.w2 + z2;
        a_next.w3 = ideau_pkg::mulmod(up_blk.w3, z3);

        b_next    = a_reg;
        m_next    = ideau_pkg::mulmod(z4, a_reg.w0 ^ a_reg.w2);

        n         = ideau_pkg::mulmod(z5, m_reg + (b_reg.w1 ^ b_reg.w3));
        s         = m_reg + n;
        c_next.w0 = b_reg.w0 ^ n;
        c_next.w1 = b_reg.w2 ^ n;
        c_next.w2 = s ^ b_reg.w1;
        c_next.w3 = b_reg.w3 ^ s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_v_reg <= up_valid;
            end
            if (b_en)
            begin
                b_v_reg <= a_v_reg;
            end
            if (c_en)
            begin
                c_v_reg <= b_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_reg <= a_next;
        end
        if (b_en)
        begin
            b_reg <= b_next;
            m_reg <= m_next;
        end
        if (c_en)
        begin
            c_reg <= c_next;
        end
    end

    assign dn_valid = c_v_reg;
    assign dn_blk   = c_reg;

endmodule

// File: hw/rtl/ideau_out_cell.sv
module ideau_out_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [63:0]       keys,
    input  logic              up_valid,
    output logic              up_ready,
    input  ideau_pkg::blk_t   up_blk,
    output logic              dn_valid,
    input  logic              dn_ready,
    output ideau_pkg::blk_t   dn_blk
);

    logic             v_reg;
    logic             en;
    ideau_pkg::blk_t  o_reg, o_next;

    assign en       = !v_reg || dn_ready;
    assign up_ready = en;

    // The middle words swap back, undoing the swap of the last round.
    always_comb
    begin
        o_next.w0 = ideau_pkg::mulmod(up_blk.w0, keys[15:0]);
        o_next.w1 = up_blk.w2 + keys[31:16];
        o_next.w2 = up_blk.w1 + keys[47:32];
        o_next.w3 = ideau_pkg::mulmod(up_blk.w3, keys[63:48]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_reg <= o_next;
        end
    end

    assign dn_valid = v_reg;
    assign dn_blk   = o_reg;

endmodule

// File: hw/rtl/idea_block_cipher_unit.sv
// Channel   Direction  Handshake            Payload
// in        request    in_valid / in_ready  in_word_0 .. in_word_3
// out       result     out_valid/out_ready  out_word_0 .. out_word_3
// cfg       write      cfg_we               cfg_index, cfg_data
//
// One block per cycle unless stalled; 8 round cells of three stages, one output stage.
// After a write to a key or mode register the round key sequencer rebuilds the table and
// in_ready stays low until it is done; in decrypt mode the rebuild includes 18 inverses
// of 16 square-and-multiply steps each.
// Reset leaves the all-zero key in encrypt mode, whose round keys are all zero.
// A stall at the output only backs up stages that hold a block; bubbles still fill.
module idea_block_cipher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] in_word_0,
    input  logic [15:0] in_word_1,
    input  logic [15:0] in_word_2,
    input  logic [15:0] in_word_3,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_word_0,
    output logic [15:0] out_word_1,
    output logic [15:0] out_word_2,
    output logic [15:0] out_word_3
);

    localparam int RC = ideau_pkg::ROUND_COUNT;

    logic [ideau_pkg::KEY_COUNT*16-1:0] keys;
    logic                               ks_busy;

    logic            vld [RC+1];
    logic            rdy [RC+1];
    ideau_pkg::blk_t blk [RC+1];

    logic            out_blk_valid;
    ideau_pkg::blk_t out_blk;

    ideau_key_sched u_key_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (ks_busy),
        .keys      (keys)
    );

    assign vld[0]    = in_valid && !ks_busy;
    assign in_ready  = rdy[0] && !ks_busy;
    assign blk[0].w0 = in_word_0;
    assign blk[0].w1 = in_word_1;
    assign blk[0].w2 = in_word_2;
    assign blk[0].w3 = in_word_3;

    for (genvar g = 0; g < RC; g++)
    begin : g_round
        ideau_round_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .keys     (keys[96*g +: 96]),
            .up_valid (vld[g]),
            .up_ready (rdy[g]),
            .up_blk   (blk[g]),
            .dn_valid (vld[g+1]),
            .dn_ready (rdy[g+1]),
            .dn_blk   (blk[g+1])
        );
    end

    ideau_out_cell u_out_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .keys     (keys[96*RC +: 64]),
        .up_valid (vld[RC]),
        .up_ready (rdy[RC]),
        .up_blk   (blk[RC]),
        .dn_valid (out_blk_valid),
        .dn_ready (out_ready),
        .dn_blk   (out_blk)
    );

    assign out_valid  = out_blk_valid;
    assign out_word_0 = out_blk.w0;
    assign out_word_1 = out_blk.w1;
    assign out_word_2 = out_blk.w2;
    assign out_word_3 = out_blk.w3;

endmodule

// File: hw/rtl/ideau_checker.sv
`include "idea_block_cipher_unit_macros.svh"

module ideau_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] out_word_0,
    input  logic [15:0] out_word_3
);

    // A stalled result keeps its words.
    `IDEAU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word_0) && $stable(out_word_3), "stalled result changed")

    // A register write starts a table rebuild that blocks requests.
    `IDEAU_ASSERT_NEXT(a_cfg_blocks, cfg_we && (cfg_index == ideau_pkg::CFG_KEY_FIRST || cfg_index == ideau_pkg::CFG_KEY_SECOND || cfg_index == ideau_pkg::CFG_MODE), !in_ready ##1 !in_ready, "request taken during key rebuild")

    // Nothing can come out in the first cycle after reset.
    `IDEAU_ASSERT_NOW(a_reset_empty, !$past(rst_n), !out_valid, "result right after reset")

endmodule

bind idea_block_cipher_unit ideau_checker u_ideau_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word_0 (out_word_0),
    .out_word_3 (out_word_3)
);

// File: tb/idea_cipher_checker.sv
`timescale 1ns / 100ps

module idea_cipher_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] in_word_0,
    input  logic [15:0] in_word_1,
    input  logic [15:0] in_word_2,
    input  logic [15:0] in_word_3,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] out_word_0,
    input  logic [15:0] out_word_1,
    input  logic [15:0] out_word_2,
    input  logic [15:0] out_word_3,
    output int          fail_count,
    output int          pending_count
);
    import ideau_pkg::*;

    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic        decrypt;
    word_t       subkeys [KEY_COUNT];
    blk_t        expected_blocks [$];

    function automatic word_t mul65537(word_t x, word_t y);
        logic [33:0] a;
        logic [33:0] b;
        logic [33:0] p;
        a = (x == 16'h0000) ? 34'h10000 : {18'd0, x};
        b = (y == 16'h0000) ? 34'h10000 : {18'd0, y};
        p = (a * b) % 34'h10001;
        return p[15:0];
    endfunction

    function automatic word_t inverse65537(word_t x);
        word_t acc;
        word_t sq;
        acc = 16'h0001;
        sq = x;
        for (int k = 0; k < 16; k++)
        begin
            acc = mul65537(acc, sq);
            sq = mul65537(sq, sq);
        end
        return acc;
    endfunction

    task automatic expand_keys();
        word_t       enc [KEY_COUNT];
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] nh;
        logic [63:0] src;
        int          w;
        int          s;
        int          t;
        hi = key_hi;
        lo = key_lo;
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            w = i & 7;
            src = (w < 4) ? hi : lo;
            enc[i] = src[(48 - 16 * (w & 3)) +: 16];
            if (w == 7)
            begin
                nh = (hi << 25) | (lo >> 39);
                lo = (lo << 25) | (hi >> 39);
                hi = nh;
            end
        end
        if (!decrypt)
        begin
            foreach (enc[i]) subkeys[i] = enc[i];
            return;
        end
        subkeys[0] = inverse65537(enc[LAST_SRC]);
        subkeys[1] = -enc[LAST_SRC + 1];
        subkeys[2] = -enc[LAST_SRC + 2];
        subkeys[3] = inverse65537(enc[LAST_SRC + 3]);
        subkeys[4] = enc[LAST_SRC - 2];
        subkeys[5] = enc[LAST_SRC - 1];
        for (int r = 1; r < ROUND_COUNT; r++)
        begin
            s = (ROUND_COUNT - r) * 6;
            t = (ROUND_COUNT - 1 - r) * 6;
            subkeys[6 * r]     = inverse65537(enc[s]);
            subkeys[6 * r + 1] = -enc[s + 2];
            subkeys[6 * r + 2] = -enc[s + 1];
            subkeys[6 * r + 3] = inverse65537(enc[s + 3]);
            subkeys[6 * r + 4] = enc[t + 4];
            subkeys[6 * r + 5] = enc[t + 5];
        end
        subkeys[LAST_SRC]     = inverse65537(enc[0]);
        subkeys[LAST_SRC + 1] = -enc[1];
        subkeys[LAST_SRC + 2] = -enc[2];
        subkeys[LAST_SRC + 3] = inverse65537(enc[3]);
    endtask

    function automatic blk_t transform_block(blk_t b);
        word_t x0;
        word_t x1;
        word_t x2;
        word_t x3;
        word_t m;
        word_t n;
        word_t s;
        word_t tmp;
        blk_t  res;
        int    z;
        x0 = b.w0;
        x1 = b.w1;
        x2 = b.w2;
        x3 = b.w3;
        for (int r = 0; r < ROUND_COUNT; r++)
        begin
            z = 6 * r;
            x0 = mul65537(x0, subkeys[z]);
            x1 = x1 + subkeys[z + 1];
            x2 = x2 + subkeys[z + 2];
            x3 = mul65537(x3, subkeys[z + 3]);
            m = mul65537(subkeys[z + 4], x0 ^ x2);
            n = mul65537(subkeys[z + 5], m + (x1 ^ x3));
            s = m + n;
            x0 = x0 ^ n;
            x3 = x3 ^ s;
            tmp = s ^ x1;
            x1 = x2 ^ n;
            x2 = tmp;
        end
        res.w0 = mul65537(x0, subkeys[LAST_SRC]);
        res.w1 = x2 + subkeys[LAST_SRC + 1];
        res.w2 = x1 + subkeys[LAST_SRC + 2];
        res.w3 = mul65537(x3, subkeys[LAST_SRC + 3]);
        return res;
    endfunction

    task automatic compare_word(string label, word_t exp_w, word_t act_w);
        if (exp_w !== act_w)
        begin
            $display("%0t %s mismatch: expected %h actual %h", $time, label, exp_w, act_w);
            fail_count++;
        end
    endtask

    assign pending_count = expected_blocks.size();

    initial
    begin
        fail_count = 0;
        key_hi = '0;
        key_lo = '0;
        decrypt = 1'b0;
        expand_keys();
    end

    always @(posedge clk)
    begin
        blk_t got;
        blk_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_FIRST:  key_hi = cfg_data;
                    CFG_KEY_SECOND: key_lo = cfg_data;
                    CFG_MODE:       decrypt = cfg_data[0];
                    default:        ;
                endcase
                if (cfg_index <= CFG_MODE)
                    expand_keys();
            end
            if (in_valid && in_ready)
                expected_blocks.push_back(transform_block(
                    '{in_word_0, in_word_1, in_word_2, in_word_3}));
            if (out_valid && out_ready)
            begin
                got = '{out_word_0, out_word_1, out_word_2, out_word_3};
                if (expected_blocks.size() == 0)
                begin
                    $display("%0t unexpected request result: expected none actual %h",
                             $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    compare_word("out_word_0", want.w0, got.w0);
                    compare_word("out_word_1", want.w1, got.w1);
                    compare_word("out_word_2", want.w2, got.w2);
                    compare_word("out_word_3", want.w3, got.w3);
                end
            end
        end
    end
endmodule

// File: tb/tb_idea_block_cipher_unit.sv
`timescale 1ns / 100ps

module tb_idea_block_cipher_unit;
    import ideau_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] in_word_0;
    logic [15:0] in_word_1;
    logic [15:0] in_word_2;
    logic [15:0] in_word_3;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] out_word_0;
    logic [15:0] out_word_1;
    logic [15:0] out_word_2;
    logic [15:0] out_word_3;
    int          fail_count;
    int          pending_count;
    int          cycle_count;
    bit          calm_phase;

    idea_block_cipher_unit uut (.*);
    idea_cipher_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog; the slowest run is far below this.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 600000)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // The result side stalls at random except during the calm stretch.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm_phase || ($urandom_range(99) >= 18);
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001;
            default: return 16'($urandom());
        endcase
    endfunction

    // Presents one request, with a random gap first outside the calm stretch, and waits for acceptance.
    task automatic send_block(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d);
        while (!calm_phase && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_word_0 <= a;
        in_word_1 <= b;
        in_word_2 <= c;
        in_word_3 <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_blocks(int count);
        for (int i = 0; i < count; i++)
            send_block(pick_word(), pick_word(), pick_word(), pick_word());
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_word_0 = '0;
        in_word_1 = '0;
        in_word_2 = '0;
        in_word_3 = '0;
        calm_phase = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All-zero round keys after reset: zero operands everywhere.
        send_block(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_block(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_block(16'h0001, 16'h0002, 16'h0003, 16'h0004);
        drain();

        write_reg(CFG_KEY_FIRST, 64'h0001_0002_0003_0004);
        write_reg(CFG_KEY_SECOND, 64'h0005_0006_0007_0008);
        send_block(16'h0000, 16'h0001, 16'h0002, 16'h0003);
        send_block(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        drain();
        write_reg(CFG_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block(16'h11FB, 16'hED2B, 16'h0198, 16'h6DE5);
        send_block(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drain();
        // Out-of-range index must leave the table alone.
        write_reg(2'd3, 64'h1234_5678_9ABC_DEF0);
        write_reg(CFG_KEY_FIRST, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_KEY_SECOND, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001);
        drain();
        write_reg(CFG_MODE, 64'd0);
        send_block(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF);
        drain();

        calm_phase = 1'b1;
        random_blocks(150);
        calm_phase = 1'b0;
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(CFG_KEY_FIRST, {$urandom(), $urandom()});
            write_reg(CFG_KEY_SECOND, {$urandom(), $urandom()});
            write_reg(CFG_MODE, {$urandom(), $urandom()});
            random_blocks(125);
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
